// ===== sv/mfap_pkg.sv =====
package mfap_pkg;

    localparam int VERT_BITS = 4;
    localparam int NUM_VERT  = 16;
    localparam int FLOW_BITS = 16;
    localparam int TOTAL_BITS = 22;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_BFS_INIT,
        ST_POP,
        ST_SCAN,
        ST_WALK_RD,
        ST_WALK_DT,
        ST_REP_RD,
        ST_REP_DT,
        ST_REP_HOLD
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  edge_tail;
        logic [3:0]  edge_head;
        logic [15:0] edge_capacity;
        logic [3:0]  source_vertex;
        logic [3:0]  sink_vertex;
    } req_t;

    typedef struct packed {
        logic [4:0]  edge_index;
        logic [15:0] edge_flow;
        logic [20:0] total_flow;
        logic        is_last;
    } rsp_t;

endpackage

// ===== sv/mfap_ram.sv =====
module mfap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/max_flow_augmenting_path.sv =====
// Edge load and clear requests are done in the idle state; a run is accepted only when idle.
// A run first clears the flow of every loaded edge, then per augmenting path sets up a search
// that scans every edge for each dequeued vertex through the edge memory's read port, and
// walks the path twice, once for the bottleneck and once to update the flows; then it
// reports each edge result and the total, and each report waits out any output stall.
// Reset (rst_n, asynchronous) empties the edge list and idles the controller.
module max_flow_augmenting_path
    import mfap_pkg::*;
#(
    parameter int MAX_EDGES = 32,
    parameter int CAP_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    localparam int CW   = (CAP_BITS < FLOW_BITS) ? CAP_BITS : FLOW_BITS;
    localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNTW = $clog2(MAX_EDGES + 1);
    localparam int EW   = 2 * VERT_BITS + CW;
    localparam int QW   = VERT_BITS + 1;

    state_t state_reg, state_next;

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] e_reg, e_next;
    logic rd_valid_reg, rd_valid_next;
    logic [EIW-1:0] rd_e_reg, rd_e_next;
    logic [VERT_BITS-1:0] src_reg, src_next, dst_reg, dst_next;
    logic [VERT_BITS-1:0] u_reg, u_next, v_reg, v_next;
    logic [NUM_VERT-1:0] visited_reg, visited_next;
    logic [EIW:0] parent_reg [NUM_VERT];
    logic [EIW:0] parent_next [NUM_VERT];
    logic [VERT_BITS-1:0] queue_reg [NUM_VERT];
    logic [VERT_BITS-1:0] queue_next [NUM_VERT];
    logic [QW-1:0] qh_reg, qh_next, qt_reg, qt_next;
    logic [QW-1:0] steps_reg, steps_next;
    logic pass_reg, pass_next;
    logic [CW-1:0] best_reg, best_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [EIW-1:0] walk_e_reg, walk_e_next;
    logic walk_dir_reg, walk_dir_next;
    rsp_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic          er_wr_en, er_rd_en;
    logic [EIW-1:0] er_wr_addr, er_rd_addr;
    logic [EW-1:0] er_wr_data, er_rd_data;
    logic          fr_wr_en, fr_rd_en;
    logic [EIW-1:0] fr_wr_addr, fr_rd_addr;
    logic [CW-1:0] fr_wr_data, fr_rd_data;

    logic [VERT_BITS-1:0] er_tail, er_head, nv;
    logic [CW-1:0] er_cap, room;
    logic fwd, bwd, hit, sink_hit, issue, accept, more_edges, walk_end;
    logic [EIW:0] plink;

    mfap_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk     (clk),
        .wr_en   (er_wr_en),
        .wr_addr (er_wr_addr),
        .wr_data (er_wr_data),
        .rd_en   (er_rd_en),
        .rd_addr (er_rd_addr),
        .rd_data (er_rd_data)
    );

    mfap_ram #(.WIDTH(CW), .DEPTH(MAX_EDGES)) u_flow_ram (
        .clk     (clk),
        .wr_en   (fr_wr_en),
        .wr_addr (fr_wr_addr),
        .wr_data (fr_wr_data),
        .rd_en   (fr_rd_en),
        .rd_addr (fr_rd_addr),
        .rd_data (fr_rd_data)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign er_tail = er_rd_data[EW-1 -: VERT_BITS];
    assign er_head = er_rd_data[CW +: VERT_BITS];
    assign er_cap  = er_rd_data[CW-1:0];

    assign fwd  = (er_tail == u_reg) && (fr_rd_data < er_cap);
    assign bwd  = !fwd && (er_head == u_reg) && (fr_rd_data != '0);
    assign nv   = fwd ? er_head : er_tail;
    assign hit  = rd_valid_reg && (fwd || bwd) && !visited_reg[nv];
    assign sink_hit = hit && (nv == dst_reg);

    assign more_edges = (e_reg < cnt_reg);
    assign issue      = (state_reg == ST_SCAN) && more_edges;
    assign plink      = parent_reg[v_reg];
    assign walk_end   = (v_reg == src_reg) || (steps_reg == QW'(NUM_VERT));
    assign room       = walk_dir_reg ? fr_rd_data : (er_cap - fr_rd_data);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.cmd == CMD_RUN)
                begin
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                if (!more_edges)
                begin
                    state_next = (src_reg == dst_reg) ? ST_REP_RD : ST_BFS_INIT;
                end
            end
            ST_BFS_INIT:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                state_next = (qh_reg == qt_reg) ? ST_REP_RD : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sink_hit)
                begin
                    state_next = ST_WALK_RD;
                end
                else if (!issue && !rd_valid_reg)
                begin
                    state_next = ST_POP;
                end
            end
            ST_WALK_RD:
            begin
                if (!walk_end)
                begin
                    state_next = ST_WALK_DT;
                end
                else if (pass_reg)
                begin
                    state_next = ST_BFS_INIT;
                end
                else if (best_reg == '0)
                begin
                    state_next = ST_REP_RD;
                end
            end
            ST_WALK_DT:
            begin
                state_next = ST_WALK_RD;
            end
            ST_REP_RD:
            begin
                state_next = more_edges ? ST_REP_DT : ST_REP_HOLD;
            end
            ST_REP_DT:
            begin
                state_next = ST_REP_HOLD;
            end
            ST_REP_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = out_reg.is_last ? ST_IDLE : ST_REP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        cnt_next      = cnt_reg;
        e_next        = e_reg;
        rd_valid_next = rd_valid_reg;
        rd_e_next     = rd_e_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        visited_next  = visited_reg;
        parent_next   = parent_reg;
        queue_next    = queue_reg;
        qh_next       = qh_reg;
        qt_next       = qt_reg;
        steps_next    = steps_reg;
        pass_next     = pass_reg;
        best_next     = best_reg;
        total_next    = total_reg;
        walk_e_next   = walk_e_reg;
        walk_dir_next = walk_dir_reg;
        out_next      = out_reg;
        out_valid_next = out_valid_reg;

        er_wr_en   = 1'b0;
        er_wr_addr = cnt_reg[EIW-1:0];
        er_wr_data = {in_data.edge_tail, in_data.edge_head, in_data.edge_capacity[CW-1:0]};
        er_rd_en   = 1'b0;
        er_rd_addr = e_reg[EIW-1:0];
        fr_wr_en   = 1'b0;
        fr_wr_addr = cnt_reg[EIW-1:0];
        fr_wr_data = '0;
        fr_rd_en   = 1'b0;
        fr_rd_addr = e_reg[EIW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.cmd)
                        CMD_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        CMD_ADD:
                        begin
                            if (cnt_reg < CNTW'(MAX_EDGES))
                            begin
                                er_wr_en = 1'b1;
                                fr_wr_en = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        CMD_RUN:
                        begin
                            src_next   = in_data.source_vertex;
                            dst_next   = in_data.sink_vertex;
                            total_next = '0;
                            e_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CLR:
            begin
                if (more_edges)
                begin
                    fr_wr_en   = 1'b1;
                    fr_wr_addr = e_reg[EIW-1:0];
                    e_next     = e_reg + 1'b1;
                end
                else
                begin
                    e_next = '0;
                end
            end
            ST_BFS_INIT:
            begin
                visited_next = '0;
                visited_next[src_reg] = 1'b1;
                queue_next[0] = src_reg;
                qh_next = '0;
                qt_next = QW'(1);
            end
            ST_POP:
            begin
                e_next = '0;
                if (qh_reg == qt_reg)
                begin
                    // no path left: report
                end
                else
                begin
                    u_next        = queue_reg[qh_reg[VERT_BITS-1:0]];
                    qh_next       = qh_reg + 1'b1;
                    rd_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                er_rd_en = issue;
                fr_rd_en = issue;
                rd_valid_next = issue;
                rd_e_next = e_reg[EIW-1:0];
                if (issue)
                begin
                    e_next = e_reg + 1'b1;
                end
                if (hit)
                begin
                    visited_next[nv] = 1'b1;
                    parent_next[nv]  = {rd_e_reg, bwd};
                    if (sink_hit)
                    begin
                        v_next     = dst_reg;
                        steps_next = '0;
                        pass_next  = 1'b0;
                        best_next  = '0;
                    end
                    else if (qt_reg < QW'(NUM_VERT))
                    begin
                        queue_next[qt_reg[VERT_BITS-1:0]] = nv;
                        qt_next = qt_reg + 1'b1;
                    end
                end
            end
            ST_WALK_RD:
            begin
                if (!walk_end)
                begin
                    er_rd_en      = 1'b1;
                    fr_rd_en      = 1'b1;
                    er_rd_addr    = plink[EIW:1];
                    fr_rd_addr    = plink[EIW:1];
                    walk_e_next   = plink[EIW:1];
                    walk_dir_next = plink[0];
                    steps_next    = steps_reg + 1'b1;
                end
                else if (pass_reg)
                begin
                    total_next = total_reg + TOTAL_BITS'(best_reg);
                end
                else if (best_reg == '0)
                begin
                    e_next = '0;
                end
                else
                begin
                    pass_next  = 1'b1;
                    v_next     = dst_reg;
                    steps_next = '0;
                end
            end
            ST_WALK_DT:
            begin
                v_next = walk_dir_reg ? er_head : er_tail;
                if (pass_reg)
                begin
                    fr_wr_en   = 1'b1;
                    fr_wr_addr = walk_e_reg;
                    fr_wr_data = walk_dir_reg ? (fr_rd_data - best_reg)
                                              : (fr_rd_data + best_reg);
                end
                else if (steps_reg == QW'(1) || room < best_reg)
                begin
                    best_next = room;
                end
            end
            ST_REP_RD:
            begin
                if (more_edges)
                begin
                    fr_rd_en = 1'b1;
                end
                else
                begin
                    out_next.edge_index = '0;
                    out_next.edge_flow  = '0;
                    out_next.total_flow = total_reg[20:0];
                    out_next.is_last    = 1'b1;
                    out_valid_next      = 1'b1;
                end
            end
            ST_REP_DT:
            begin
                out_next.edge_index = 5'(e_reg);
                out_next.edge_flow  = 16'(fr_rd_data);
                out_next.total_flow = '0;
                out_next.is_last    = 1'b0;
                out_valid_next      = 1'b1;
            end
            ST_REP_HOLD:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    e_next = e_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            e_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            qh_reg        <= '0;
            qt_reg        <= '0;
            steps_reg     <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            visited_reg   <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            e_reg         <= e_next;
            rd_valid_reg  <= rd_valid_next;
            qh_reg        <= qh_next;
            qt_reg        <= qt_next;
            steps_reg     <= steps_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
            visited_reg   <= visited_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_e_reg     <= rd_e_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        parent_reg   <= parent_next;
        queue_reg    <= queue_next;
        best_reg     <= best_next;
        walk_e_reg   <= walk_e_next;
        walk_dir_reg <= walk_dir_next;
        out_reg      <= out_next;
    end

endmodule
